// ===== hdl/cosine_nearest_profile_core_defines.svh =====
// Assertion macros shared by the cosine nearest profile core.
// Each macro expects signals named clk and arst_n in the using module.
`ifndef COSINE_NEAREST_PROFILE_CORE_DEFINES_SVH
`define COSINE_NEAREST_PROFILE_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CNP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define CNP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CNP_ASSERT_IMP(lbl, ante, cons, msg)
`define CNP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/cnp_pkg.sv =====
// ---------------------------------------------------------------------------
// cnp_pkg
// Types and constants shared by the controller and datapath of the
// cosine nearest profile core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package cnp_pkg;

	localparam int NFACT = 5;

	localparam logic [1:0] FUNC_ANSWER  = 2'd0;
	localparam logic [1:0] FUNC_PROFILE = 2'd1;
	localparam logic [1:0] FUNC_FINISH  = 2'd2;

	localparam logic [1:0] STAT_MATCH = 2'd0;
	localparam logic [1:0] STAT_ZERO  = 2'd1;
	localparam logic [1:0] STAT_NONE  = 2'd2;

	localparam logic [1:0] MAC_DOT = 2'd0;
	localparam logic [1:0] MAC_UU  = 2'd1;
	localparam logic [1:0] MAC_PP  = 2'd2;

	localparam logic [2:0] IDX_LAST  = 3'd4;
	localparam logic [4:0] ROOT_LAST = 5'd31;
	localparam logic [4:0] DIV_LAST  = 5'd16;

	// Scaled vectors have their largest magnitude in [2^13, 2^14).
	localparam int SCL_TOP = 13;

	typedef struct packed {
		logic       answer;
		logic       prof_load;
		logic       finish;
		logic       scl_load_user;
		logic       scl_load_prof;
		logic       scl_step;
		logic       store_user;
		logic       store_prof;
		logic       zero_sim;
		logic       mac_step;
		logic [1:0] mac_op;
		logic [2:0] mac_idx;
		logic       root_init;
		logic       root_step;
		logic       div_init;
		logic       div_step;
		logic       update;
	} cnp_cmd_t;

	typedef struct packed {
		logic scl_zero;
		logic scl_fit;
	} cnp_sts_t;

endpackage
`default_nettype wire

// ===== hdl/cosine_nearest_profile_core.sv =====
// Answer and finish need no sequencer steps; a finish result waits in the output register.
// A profile transaction stalls the input through scaling shifts and fit checks, 15 shared
// multiplies, drain, a 31x31 multiply, 32 root and 17 divide steps. Shifts: user vector up
// to the larger of 13 and SUM_WIDTH-14, profile 3 to 13. A zero vector ends the work early,
// at its scaling check, before any product is taken.
// Asynchronous active-low reset clears the factor sums, the best match and the output valid.
// ---------------------------------------------------------------------------
// cosine_nearest_profile_core
// Nearest personality profile by cosine similarity of five-factor vectors.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module cosine_nearest_profile_core #(
	parameter int SUM_WIDTH = 24,
	parameter int ID_WIDTH  = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         func,
	input  wire logic signed [2:0]  answer,
	input  wire logic signed [10:0] value_o,
	input  wire logic signed [10:0] value_c,
	input  wire logic signed [10:0] value_e,
	input  wire logic signed [10:0] value_a,
	input  wire logic signed [10:0] value_n,
	input  wire logic [7:0]         person_id,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [7:0]              best_person,
	output logic signed [15:0]      similarity_q15,
	output logic [1:0]              status
);
	import cnp_pkg::*;

	cnp_cmd_t cmd;
	cnp_sts_t sts;

	cnp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	cnp_dpath #(
		.SUM_WIDTH (SUM_WIDTH),
		.ID_WIDTH  (ID_WIDTH)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.answer         (answer),
		.value_o        (value_o),
		.value_c        (value_c),
		.value_e        (value_e),
		.value_a        (value_a),
		.value_n        (value_n),
		.person_id      (person_id),
		.best_person    (best_person),
		.similarity_q15 (similarity_q15),
		.status         (status)
	);

endmodule
`default_nettype wire

// ===== hdl/cnp_ctrl.sv =====
// ---------------------------------------------------------------------------
// cnp_ctrl
// Sequencer for the cosine nearest profile core: input and output handshake
// and the step order of scaling, products, square root and division.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "cosine_nearest_profile_core_defines.svh"
module cnp_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [1:0]       func,
	output logic                  out_valid,
	input  wire logic             out_stall,
	input  wire cnp_pkg::cnp_sts_t sts,
	output cnp_pkg::cnp_cmd_t     cmd
);
	import cnp_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SCL_U = 4'd1;
	localparam logic [3:0] S_SCL_P = 4'd2;
	localparam logic [3:0] S_MAC   = 4'd3;
	localparam logic [3:0] S_DRAIN = 4'd4;
	localparam logic [3:0] S_RMUL  = 4'd5;
	localparam logic [3:0] S_ROOT  = 4'd6;
	localparam logic [3:0] S_DINIT = 4'd7;
	localparam logic [3:0] S_DIV   = 4'd8;
	localparam logic [3:0] S_UPD   = 4'd9;

	logic [3:0] state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic [1:0] op_q, op_d;
	logic [2:0] idx_q, idx_d;
	logic       out_valid_q;
	logic       in_acc;

	assign in_stall  = (state_q != S_IDLE) || (out_valid_q && func == FUNC_FINISH);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		cnt_d   = cnt_q;
		op_d    = op_q;
		idx_d   = idx_q;
		cmd.mac_op  = op_q;
		cmd.mac_idx = idx_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					case (func)
						FUNC_ANSWER: cmd.answer = 1'b1;
						FUNC_PROFILE: begin
							cmd.prof_load     = 1'b1;
							cmd.scl_load_user = 1'b1;
							state_d           = S_SCL_U;
						end
						FUNC_FINISH: cmd.finish = 1'b1;
						default: ;
					endcase
				end
			end
			S_SCL_U: begin
				if (sts.scl_zero) begin
					cmd.zero_sim = 1'b1;
					state_d      = S_UPD;
				end else if (sts.scl_fit) begin
					cmd.store_user    = 1'b1;
					cmd.scl_load_prof = 1'b1;
					state_d           = S_SCL_P;
				end else begin
					cmd.scl_step = 1'b1;
				end
			end
			S_SCL_P: begin
				if (sts.scl_zero) begin
					cmd.zero_sim = 1'b1;
					state_d      = S_UPD;
				end else if (sts.scl_fit) begin
					cmd.store_prof = 1'b1;
					op_d           = MAC_DOT;
					idx_d          = '0;
					state_d        = S_MAC;
				end else begin
					cmd.scl_step = 1'b1;
				end
			end
			S_MAC: begin
				cmd.mac_step = 1'b1;
				if (idx_q == IDX_LAST) begin
					idx_d = '0;
					op_d  = op_q + 2'd1;
					if (op_q == MAC_PP) state_d = S_DRAIN;
				end else begin
					idx_d = idx_q + 3'd1;
				end
			end
			S_DRAIN: state_d = S_RMUL;
			S_RMUL: begin
				cmd.root_init = 1'b1;
				cnt_d         = '0;
				state_d       = S_ROOT;
			end
			S_ROOT: begin
				cmd.root_step = 1'b1;
				cnt_d         = cnt_q + 5'd1;
				if (cnt_q == ROOT_LAST) state_d = S_DINIT;
			end
			S_DINIT: begin
				cmd.div_init = 1'b1;
				cnt_d        = '0;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 5'd1;
				if (cnt_q == DIV_LAST) state_d = S_UPD;
			end
			S_UPD: begin
				cmd.update = 1'b1;
				state_d    = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			op_q        <= MAC_DOT;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			op_q    <= op_d;
			idx_q   <= idx_d;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	`CNP_ASSERT_NXT(a_prof_starts, in_acc && func == FUNC_PROFILE, state_q == S_SCL_U, "profile transaction did not start scaling")
	`CNP_ASSERT_IMP(a_out_from_finish, $rose(out_valid_q), $past(in_acc && func == FUNC_FINISH), "result raised without a finish transaction")
	`CNP_ASSERT_IMP(a_div_bound, state_q == S_DIV, cnt_q <= DIV_LAST, "division step count overran")

endmodule
`default_nettype wire

// ===== hdl/cnp_dpath.sv =====
// ---------------------------------------------------------------------------
// cnp_dpath
// Datapath: user factor sums, vector scaler, shared multiplier with
// accumulators, bit-serial square root, restoring divider and best match.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module cnp_dpath #(
	parameter int SUM_WIDTH = 24,
	parameter int ID_WIDTH  = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cnp_pkg::cnp_cmd_t  cmd,
	output cnp_pkg::cnp_sts_t       sts,
	input  wire logic signed [2:0]  answer,
	input  wire logic signed [10:0] value_o,
	input  wire logic signed [10:0] value_c,
	input  wire logic signed [10:0] value_e,
	input  wire logic signed [10:0] value_a,
	input  wire logic signed [10:0] value_n,
	input  wire logic [7:0]         person_id,
	output logic [7:0]              best_person,
	output logic signed [15:0]      similarity_q15,
	output logic [1:0]              status
);
	import cnp_pkg::*;

	localparam int SW = SUM_WIDTH;

	logic signed [10:0]   val_in [NFACT];
	logic signed [SW-1:0] sum_q [NFACT];
	logic signed [10:0]   prof_q [NFACT];
	logic [ID_WIDTH-1:0]  id_q;
	logic [ID_WIDTH-1:0]  best_id_q;
	logic signed [15:0]   best_sim_q;
	logic                 have_best_q;
	logic                 sim_zero_q;
	logic [SW-1:0]        mag_q [NFACT];
	logic [NFACT-1:0]     sgn_q;
	logic [SW-1:0]        mag_or;
	logic signed [14:0]   u_q [NFACT];
	logic signed [14:0]   p_q [NFACT];
	logic signed [14:0]   opa, opb;
	logic signed [29:0]   prod_s1;
	logic [1:0]           tag_s1;
	logic                 vld_s1;
	logic signed [31:0]   dot_q;
	logic [30:0]          uu_q, pp_q;
	logic [61:0]          x_q;
	logic [62:0]          r_q, bit_q, r_try;
	logic [46:0]          rem_q, dsh_q;
	logic [16:0]          q_q;
	logic [30:0]          dot_mag;
	logic [31:0]          dot_abs;
	logic signed [15:0]   sim;
	logic [16:0]          q_neg;
	logic                 all_zero;
	logic [ID_WIDTH+7:0]  id_ext, best_ext;

	assign val_in[0] = value_o;
	assign val_in[1] = value_c;
	assign val_in[2] = value_e;
	assign val_in[3] = value_a;
	assign val_in[4] = value_n;

	assign id_ext   = {{ID_WIDTH{1'b0}}, person_id};
	assign best_ext = {8'b0, best_id_q};

	always_comb begin
		mag_or   = '0;
		all_zero = 1'b1;
		for (int i = 0; i < NFACT; i++) begin
			mag_or = mag_or | mag_q[i];
			if (sum_q[i] != '0) all_zero = 1'b0;
		end
	end

	assign sts.scl_zero = (mag_or == '0);
	assign sts.scl_fit  = ((mag_or >> (SCL_TOP + 1)) == '0) && mag_or[SCL_TOP];

	assign opa = (cmd.mac_op == MAC_PP) ? p_q[cmd.mac_idx] : u_q[cmd.mac_idx];
	assign opb = (cmd.mac_op == MAC_UU) ? u_q[cmd.mac_idx] : p_q[cmd.mac_idx];

	assign r_try   = r_q + bit_q;
	assign dot_abs = dot_q[31] ? -dot_q : dot_q;
	assign dot_mag = dot_abs[30:0];
	assign q_neg   = -q_q;

	always_comb begin
		if (sim_zero_q) begin
			sim = '0;
		end else if (dot_q[31]) begin
			sim = (q_q > 17'd32768) ? 16'sh8000 : q_neg[15:0];
		end else begin
			sim = (q_q > 17'd32767) ? 16'sh7fff : q_q[15:0];
		end
	end

	// Factor sums and best match are architectural state and reset to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NFACT; i++) sum_q[i] <= '0;
			best_id_q   <= '0;
			best_sim_q  <= '0;
			have_best_q <= 1'b0;
			sim_zero_q  <= 1'b0;
			vld_s1      <= 1'b0;
		end else begin
			vld_s1 <= cmd.mac_step;
			if (cmd.answer) begin
				for (int i = 0; i < NFACT; i++) begin
					logic signed [13:0] p;
					logic signed [SW:0] s;
					p = val_in[i] * answer;
					s = {sum_q[i][SW-1], sum_q[i]} + {{(SW - 13){p[13]}}, p};
					if (s[SW] != s[SW-1])
						sum_q[i] <= s[SW] ? {1'b1, {(SW - 1){1'b0}}} : {1'b0, {(SW - 1){1'b1}}};
					else
						sum_q[i] <= s[SW-1:0];
				end
			end
			if (cmd.prof_load) sim_zero_q <= 1'b0;
			else if (cmd.zero_sim) sim_zero_q <= 1'b1;
			if (cmd.update && (!have_best_q || sim >= best_sim_q)) begin
				best_sim_q  <= sim;
				best_id_q   <= id_q;
				have_best_q <= 1'b1;
			end
			if (cmd.finish) begin
				for (int i = 0; i < NFACT; i++) sum_q[i] <= '0;
				best_id_q   <= '0;
				best_sim_q  <= '0;
				have_best_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prof_load) begin
			for (int i = 0; i < NFACT; i++) prof_q[i] <= val_in[i];
			id_q <= id_ext[ID_WIDTH-1:0];
		end
		// Scaler: right shifts truncate the magnitude, the sign is kept apart.
		if (cmd.scl_load_user) begin
			for (int i = 0; i < NFACT; i++) begin
				mag_q[i] <= sum_q[i][SW-1] ? -sum_q[i] : sum_q[i];
				sgn_q[i] <= sum_q[i][SW-1];
			end
		end else if (cmd.scl_load_prof) begin
			for (int i = 0; i < NFACT; i++) begin
				logic signed [SW-1:0] e;
				e = {{(SW - 11){prof_q[i][10]}}, prof_q[i]};
				mag_q[i] <= e[SW-1] ? -e : e;
				sgn_q[i] <= e[SW-1];
			end
		end else if (cmd.scl_step) begin
			for (int i = 0; i < NFACT; i++) begin
				if ((mag_or >> (SCL_TOP + 1)) != '0) mag_q[i] <= mag_q[i] >> 1;
				else mag_q[i] <= mag_q[i] << 1;
			end
		end
		if (cmd.store_user) begin
			for (int i = 0; i < NFACT; i++)
				u_q[i] <= sgn_q[i] ? -{1'b0, mag_q[i][13:0]} : {1'b0, mag_q[i][13:0]};
		end
		if (cmd.store_prof) begin
			for (int i = 0; i < NFACT; i++)
				p_q[i] <= sgn_q[i] ? -{1'b0, mag_q[i][13:0]} : {1'b0, mag_q[i][13:0]};
			dot_q <= '0;
			uu_q  <= '0;
			pp_q  <= '0;
		end else if (vld_s1) begin
			case (tag_s1)
				MAC_DOT: dot_q <= dot_q + {{2{prod_s1[29]}}, prod_s1};
				MAC_UU:  uu_q  <= uu_q + {1'b0, prod_s1[29:0]};
				MAC_PP:  pp_q  <= pp_q + {1'b0, prod_s1[29:0]};
				default: ;
			endcase
		end
		if (cmd.mac_step) begin
			prod_s1 <= opa * opb;
			tag_s1  <= cmd.mac_op;
		end
		if (cmd.root_init) begin
			x_q   <= uu_q * pp_q;
			r_q   <= '0;
			bit_q <= {1'b1, 62'b0};
		end else if (cmd.root_step) begin
			if ({1'b0, x_q} >= r_try) begin
				x_q <= x_q - r_try[61:0];
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.div_init) begin
			rem_q <= {1'b0, dot_mag, 15'b0} + {17'b0, r_q[30:1]};
			dsh_q <= {r_q[30:0], 16'b0};
			q_q   <= '0;
		end else if (cmd.div_step) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				q_q   <= {q_q[15:0], 1'b1};
			end else begin
				q_q <= {q_q[15:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
		if (cmd.finish) begin
			if (all_zero) begin
				best_person    <= '0;
				similarity_q15 <= '0;
				status         <= STAT_ZERO;
			end else if (!have_best_q) begin
				best_person    <= '0;
				similarity_q15 <= '0;
				status         <= STAT_NONE;
			end else begin
				best_person    <= best_ext[7:0];
				similarity_q15 <= best_sim_q;
				status         <= STAT_MATCH;
			end
		end
	end

endmodule
`default_nettype wire

// ===== test/tb_cosine_nearest_profile_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_cosine_nearest_profile_core
// Self-checking bench: answer, profile and finish transactions go in, with
// random gaps on the input and random stalls on the output. A scoreboard
// tracks the factor sums and best match, and predicts each finish report.
// ---------------------------------------------------------------------------
module tb_cosine_nearest_profile_core;
	import cnp_pkg::*;

	localparam logic [1:0] FUNC_SPARE = 2'd3;
	localparam longint SUM_MAX = (64'sd1 <<< 23) - 1;
	localparam longint SUM_MIN = -(64'sd1 <<< 23);

	typedef struct {
		logic [1:0]         func;
		logic signed [2:0]  ans;
		logic signed [10:0] v [5];
		logic [7:0]         id;
	} txn_t;

	class match_scoreboard;
		longint             sums [5];
		logic [7:0]         best_id;
		int                 best_sim;
		bit                 have_best;
		logic [25:0]        reports [$];
		int                 mismatches;

		function void clear_state();
			foreach (sums[i]) sums[i] = 0;
			best_id = 0;
			best_sim = 0;
			have_best = 0;
		endfunction

		function longint unsigned int_sqrt(longint unsigned x);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > x) b >>= 2;
			while (b != 0) begin
				if (x >= r + b) begin
					x -= r + b;
					r = (r >> 1) + b;
				end else
					r >>= 1;
				b >>= 2;
			end
			return r;
		endfunction

		// Brings the largest magnitude into [2^13, 2^14); right shifts truncate magnitudes.
		function bit normalise(input longint a [5], output longint w [5]);
			longint unsigned mx, m;
			int rs, ls;
			mx = 0;
			rs = 0;
			ls = 0;
			foreach (a[i]) begin
				m = a[i] < 0 ? -a[i] : a[i];
				if (m > mx) mx = m;
			end
			foreach (w[i]) w[i] = 0;
			if (mx == 0) return 0;
			while (mx >= (64'd1 << 14)) begin mx >>= 1; rs++; end
			while (mx < (64'd1 << 13)) begin mx <<= 1; ls++; end
			foreach (a[i]) begin
				m = ((a[i] < 0 ? -a[i] : a[i]) >> rs) << ls;
				w[i] = a[i] < 0 ? -longint'(m) : longint'(m);
			end
			return 1;
		endfunction

		function int cosine_q15(input longint prof [5]);
			longint u [5], p [5], dot;
			longint unsigned uu, pp, d, m, ad;
			dot = 0;
			uu = 0;
			pp = 0;
			if (!normalise(sums, u) || !normalise(prof, p)) return 0;
			foreach (u[i]) begin
				dot += u[i] * p[i];
				uu += u[i] * u[i];
				pp += p[i] * p[i];
			end
			d = int_sqrt(uu * pp);
			if (d == 0) return 0;
			ad = dot < 0 ? -dot : dot;
			m = (ad * 32768 + d / 2) / d;
			if (dot >= 0) return m > 32767 ? 32767 : int'(m);
			return m > 32768 ? -32768 : -int'(m);
		endfunction

		function void note_input(txn_t t);
			longint vals [5];
			longint s;
			bit all_zero;
			int sim;
			foreach (vals[i]) vals[i] = t.v[i];
			case (t.func)
				FUNC_ANSWER: begin
					foreach (sums[i]) begin
						s = sums[i] + vals[i] * longint'(t.ans);
						sums[i] = s > SUM_MAX ? SUM_MAX : (s < SUM_MIN ? SUM_MIN : s);
					end
				end
				FUNC_PROFILE: begin
					sim = cosine_q15(vals);
					if (!have_best || sim >= best_sim) begin
						best_sim = sim;
						best_id = t.id;
						have_best = 1;
					end
				end
				FUNC_FINISH: begin
					all_zero = 1;
					foreach (sums[i]) if (sums[i] != 0) all_zero = 0;
					if (all_zero)
						reports.push_back({8'd0, 16'd0, STAT_ZERO});
					else if (!have_best)
						reports.push_back({8'd0, 16'd0, STAT_NONE});
					else
						reports.push_back({best_id, 16'(best_sim), STAT_MATCH});
					clear_state();
				end
				default: ;
			endcase
		endfunction

		function void check_result(logic [7:0] bp, logic [15:0] sim, logic [1:0] st);
			logic [25:0] exp_r;
			if (reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected report: person %0d sim %0d status %0d",
						bp, $signed(sim), st);
				return;
			end
			exp_r = reports.pop_front();
			if (exp_r !== {bp, sim, st}) begin
				mismatches++;
				if (mismatches <= 10)
					$display("report mismatch: expected person %0d sim %0d status %0d, got %0d %0d %0d",
						exp_r[25:18], $signed(exp_r[17:2]), exp_r[1:0], bp, $signed(sim), st);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [1:0] func;
	logic signed [2:0] answer;
	logic signed [10:0] value_o, value_c, value_e, value_a, value_n;
	logic [7:0] person_id, best_person;
	logic signed [15:0] similarity_q15;
	logic [1:0] status;

	match_scoreboard sb;
	int idle_pct, stall_pct;

	cosine_nearest_profile_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .answer(answer),
		.value_o(value_o), .value_c(value_c), .value_e(value_e),
		.value_a(value_a), .value_n(value_n), .person_id(person_id),
		.out_valid(out_valid), .out_stall(out_stall),
		.best_person(best_person), .similarity_q15(similarity_q15), .status(status)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4ms;
		$display("status: fail");
		$finish;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
		if (arst_n && out_valid && !out_stall)
			sb.check_result(best_person, similarity_q15, status);
	end

	task automatic send(txn_t t);
		int gap;
		gap = 0;
		if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, 6);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		func <= t.func;
		answer <= t.ans;
		value_o <= t.v[0];
		value_c <= t.v[1];
		value_e <= t.v[2];
		value_a <= t.v[3];
		value_n <= t.v[4];
		person_id <= t.id;
		do @(posedge clk); while (in_stall);
		sb.note_input(t);
	endtask

	task automatic send_one(logic [1:0] f, logic signed [2:0] a, int v0, int v1, int v2,
			int v3, int v4, logic [7:0] id);
		txn_t t;
		t.func = f;
		t.ans = a;
		t.v[0] = v0; t.v[1] = v1; t.v[2] = v2; t.v[3] = v3; t.v[4] = v4;
		t.id = id;
		send(t);
	endtask

	function automatic txn_t random_txn(logic [1:0] f);
		txn_t t;
		int mode;
		t.func = f;
		t.ans = $urandom;
		t.id = $urandom;
		mode = $urandom_range(9);
		foreach (t.v[i]) begin
			case (mode)
				0: t.v[i] = $urandom_range(3) == 0 ? 11'sd0 : 11'($urandom_range(7) - 4);
				1: t.v[i] = $urandom_range(1) ? 11'h3ff : 11'h400;
				default: t.v[i] = $urandom;
			endcase
		end
		if (f == FUNC_PROFILE && $urandom_range(19) == 0)
			foreach (t.v[i]) t.v[i] = 0;
		return t;
	endfunction

	// One user session: answers, profiles and spare function codes interleaved, then a finish.
	task automatic run_session(output int n);
		int k;
		txn_t t;
		n = 0;
		k = $urandom_range(1, 14);
		repeat (k) begin
			case ($urandom_range(19))
				0: t = random_txn(FUNC_SPARE);
				1, 2, 3, 4, 5, 6, 7, 8: t = random_txn(FUNC_PROFILE);
				default: t = random_txn(FUNC_ANSWER);
			endcase
			send(t);
			n++;
		end
		send(random_txn(FUNC_FINISH));
		n++;
	endtask

	initial begin
		int n, total, ph;
		sb = new();
		sb.clear_state();
		idle_pct = 0;
		stall_pct = 0;
		in_valid = 0;
		out_stall = 0;
		func = FUNC_ANSWER;
		answer = 0;
		value_o = 0; value_c = 0; value_e = 0; value_a = 0; value_n = 0;
		person_id = 0;
		arst_n = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Empty session, then a profile with no answers: both report a zero user vector.
		send_one(FUNC_FINISH, 0, 0, 0, 0, 0, 0, 0);
		send_one(FUNC_PROFILE, 0, 100, -3, 7, 0, 1, 8'd9);
		send_one(FUNC_FINISH, 0, 0, 0, 0, 0, 0, 0);
		// Answers but no profile, with the out-of-range answer codes.
		send_one(FUNC_ANSWER, 3, 1023, -1024, 5, 0, -1, 0);
		send_one(FUNC_ANSWER, -4, -1024, 1023, 0, 2, 0, 0);
		send_one(FUNC_ANSWER, -3, 1, 1, 1, 1, 1, 0);
		send_one(FUNC_SPARE, 1, 1, 1, 1, 1, 1, 8'hff);
		send_one(FUNC_FINISH, 0, 0, 0, 0, 0, 0, 0);
		// Ties: later profile wins, zero profile competes; last answer zeroes the sums.
		send_one(FUNC_ANSWER, 2, 10, -20, 30, -40, 50, 0);
		send_one(FUNC_PROFILE, 0, 0, 0, 0, 0, 0, 8'd1);
		send_one(FUNC_PROFILE, 0, 1, -2, 3, -4, 5, 8'd2);
		send_one(FUNC_PROFILE, 0, 1, -2, 3, -4, 5, 8'd255);
		send_one(FUNC_PROFILE, 0, -1, 2, -3, 4, -5, 8'd3);
		send_one(FUNC_ANSWER, -2, 10, -20, 30, -40, 50, 0);
		send_one(FUNC_FINISH, 0, 0, 0, 0, 0, 0, 0);
		// Exactly opposite vectors give the most negative similarity.
		send_one(FUNC_ANSWER, 1, -1024, -1024, -1024, -1024, -1024, 0);
		send_one(FUNC_PROFILE, 0, 1023, 1023, 1023, 1023, 1023, 8'd128);
		send_one(FUNC_FINISH, 0, 0, 0, 0, 0, 0, 0);

		total = 0;
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 75; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 75; end
				default: begin idle_pct = 33; stall_pct = 33; end
			endcase
			while (total < 190 * (ph + 1)) begin
				run_session(n);
				total += n;
			end
		end

		// Large factor sums, which the scaler has to shift right before scoring.
		idle_pct = 0;
		stall_pct = 33;
		repeat (20) send_one(FUNC_ANSWER, 3, 1023, -1024, 1023, -1024, 1023, 0);
		send_one(FUNC_PROFILE, 0, 600, -600, 600, -600, 300, 8'd77);
		send_one(FUNC_FINISH, 0, 0, 0, 0, 0, 0, 0);
		repeat (20) send_one(FUNC_ANSWER, -4, 1023, -1024, 7, 1023, -1024, 0);
		send_one(FUNC_PROFILE, 0, -5, 5, 0, -5, 5, 8'd66);
		send_one(FUNC_FINISH, 0, 0, 0, 0, 0, 0, 0);

		in_valid <= 0;
		while (sb.reports.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/cnp_pkg.sv
hdl/cnp_ctrl.sv
hdl/cnp_dpath.sv
hdl/cosine_nearest_profile_core.sv
test/tb_cosine_nearest_profile_core.sv
